[hw/rtl/ittf_pkg.sv]
// ittf_pkg: shared types, field widths, kind codes and character codes
// used by the integer-to-text formatter modules; depends on nothing
package ittf_pkg;

    localparam int VALUE_W    = 64;
    localparam int KIND_W     = 3;
    localparam int PAD_W      = 6;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 20;
    localparam int DIGITS_W   = DIGIT_W * NUM_DIGITS;
    localparam int NDIG_W     = 5;
    localparam int BITCNT_W   = 6;

    localparam logic [KIND_W-1:0] KIND_S32 = 3'd0;
    localparam logic [KIND_W-1:0] KIND_U32 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_H32 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_S64 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_U64 = 3'd4;
    localparam logic [KIND_W-1:0] KIND_H64 = 3'd5;

    localparam logic [CHAR_W-1:0] CH_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0] CH_HEX_BASE = 7'd55;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 7'd45;
    localparam logic [DIGIT_W-1:0] DEC_BASE   = 4'd10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [KIND_W-1:0]  format_kind;
        logic [PAD_W-1:0]   pad_width;
    } fmt_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } fmt_result_t;

    typedef struct packed {
        logic                valid;
        logic                neg;
        logic [PAD_W-1:0]    pad;
        logic [DIGITS_W-1:0] digits;
    } conv_res_t;

endpackage

[hw/rtl/ittf_conv.sv]
// ittf_conv: derives magnitude and sign of one value and builds its digit
// string, hex directly, decimal by bit-serial shift-and-add-3; uses ittf_pkg
module ittf_conv
    import ittf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  fmt_item_t item,
    output logic      busy,
    output conv_res_t res
);

    typedef enum logic [1:0] {
        CV_IDLE = 2'b01,
        CV_RUN  = 2'b10
    } conv_state_t;

    conv_state_t         state_reg, state_next;
    logic                done_reg, done_next;
    logic                neg_reg, neg_next;
    logic [PAD_W-1:0]    pad_reg, pad_next;
    logic [DIGITS_W-1:0] bcd_reg, bcd_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BITCNT_W-1:0] cnt_reg, cnt_next;

    logic                kind_ok;
    logic                is_hex;
    logic                is_neg;
    logic [VALUE_W-1:0]  mag;
    logic [31:0]         low32;
    logic [DIGITS_W-1:0] bcd_adj;

    always_comb
    begin
        low32   = item.value[31:0];
        kind_ok = 1'b1;
        is_hex  = 1'b0;
        is_neg  = 1'b0;
        mag     = item.value;
        case (item.format_kind)
            KIND_S32:
            begin
                is_neg = low32[31];
                mag    = {32'd0, (low32[31] ? (32'd0 - low32) : low32)};
            end
            KIND_U32:
            begin
                mag = {32'd0, low32};
            end
            KIND_H32:
            begin
                mag    = {32'd0, low32};
                is_hex = 1'b1;
            end
            KIND_S64:
            begin
                is_neg = item.value[VALUE_W-1];
                mag    = item.value[VALUE_W-1] ? (64'd0 - item.value) : item.value;
            end
            KIND_U64:
            begin
                mag = item.value;
            end
            KIND_H64:
            begin
                is_hex = 1'b1;
            end
            default:
            begin
                kind_ok = 1'b0;
            end
        endcase
    end

    // add 3 to every bcd digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        pad_next   = pad_reg;
        bcd_next   = bcd_reg;
        bin_next   = bin_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            CV_IDLE:
            begin
                if (load && kind_ok)
                begin
                    neg_next = is_neg;
                    pad_next = item.pad_width;
                    if (is_hex)
                    begin
                        bcd_next  = {{(DIGITS_W-VALUE_W){1'b0}}, mag};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        bcd_next   = '0;
                        bin_next   = mag;
                        cnt_next   = '1;
                        state_next = CV_RUN;
                    end
                end
            end
            CV_RUN:
            begin
                bcd_next = {bcd_adj[DIGITS_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        pad_reg <= pad_next;
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
        cnt_reg <= cnt_next;
    end

    assign busy       = (state_reg != CV_IDLE) || done_reg;
    assign res.valid  = done_reg;
    assign res.neg    = neg_reg;
    assign res.pad    = pad_reg;
    assign res.digits = bcd_reg;

endmodule

[hw/rtl/ittf_emit.sv]
// ittf_emit: drops leading zero digits, then sends sign, pad zeros and digits
// one character per cycle, most significant first; uses ittf_pkg
module ittf_emit
    import ittf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  conv_res_t   conv,
    output logic        busy,
    output logic        strobe,
    output fmt_result_t result
);

    typedef enum logic [2:0] {
        EM_IDLE = 3'b001,
        EM_SKIP = 3'b010,
        EM_SEND = 3'b100
    } emit_state_t;

    emit_state_t         state_reg, state_next;
    logic [DIGITS_W-1:0] dig_reg, dig_next;
    logic [NDIG_W-1:0]   nd_reg, nd_next;
    logic                sign_reg, sign_next;
    logic [PAD_W-1:0]    pad_reg, pad_next;
    logic [PAD_W-1:0]    zcnt_reg, zcnt_next;
    logic                strobe_reg, strobe_next;
    fmt_result_t         res_reg, res_next;

    logic [DIGIT_W-1:0]  top_dig;
    logic [PAD_W-1:0]    text_len;
    logic [CHAR_W-1:0]   dig_char;

    always_comb
    begin
        top_dig  = dig_reg[DIGITS_W-1 -: DIGIT_W];
        text_len = {1'b0, nd_reg} + {{(PAD_W-1){1'b0}}, sign_reg};
        if (top_dig < DEC_BASE)
            dig_char = CH_ZERO + {3'd0, top_dig};
        else
            dig_char = CH_HEX_BASE + {3'd0, top_dig};
    end

    always_comb
    begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        nd_next     = nd_reg;
        sign_next   = sign_reg;
        pad_next    = pad_reg;
        zcnt_next   = zcnt_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        case (state_reg)
            EM_IDLE:
            begin
                if (conv.valid)
                begin
                    dig_next   = conv.digits;
                    nd_next    = NDIG_W'(NUM_DIGITS);
                    sign_next  = conv.neg;
                    pad_next   = conv.pad;
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP:
            begin
                if ((top_dig == '0) && (nd_reg > 5'd1))
                begin
                    dig_next = {dig_reg[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    nd_next  = nd_reg - 1'b1;
                end
                else
                begin
                    zcnt_next  = (pad_reg > text_len) ? (pad_reg - text_len) : '0;
                    state_next = EM_SEND;
                end
            end
            EM_SEND:
            begin
                strobe_next = 1'b1;
                if (sign_reg)
                begin
                    res_next.char_code = CH_MINUS;
                    res_next.last      = 1'b0;
                    sign_next          = 1'b0;
                end
                else if (zcnt_reg != '0)
                begin
                    res_next.char_code = CH_ZERO;
                    res_next.last      = 1'b0;
                    zcnt_next          = zcnt_reg - 1'b1;
                end
                else
                begin
                    res_next.char_code = dig_char;
                    res_next.last      = (nd_reg == 5'd1);
                    dig_next = {dig_reg[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    nd_next  = nd_reg - 1'b1;
                    if (nd_reg == 5'd1)
                        state_next = EM_IDLE;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EM_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        nd_reg   <= nd_next;
        sign_reg <= sign_next;
        pad_reg  <= pad_next;
        zcnt_reg <= zcnt_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != EM_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

[hw/rtl/integer_to_text_formatter.sv]
// integer_to_text_formatter: top level, printf-style integer to ascii text
// depends on ittf_pkg, ittf_conv and ittf_emit
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  item in  | start high, busy low| item   (value, format_kind, pad_width)
//  char out | strobe, one cycle   | result (char_code, last)
//
// hex kinds: the value is loaded and leading zero digits are dropped, then
// characters go out one per cycle; decimal kinds add a bit-serial
// binary-to-bcd conversion before that
// busy stays high from the accepted transaction to its last character;
// unused kinds are taken and produce nothing; reset clears all control state
// each character is shown for one cycle and the receiver cannot stall it
module integer_to_text_formatter
    import ittf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  fmt_item_t   item,
    output logic        busy,
    output logic        strobe,
    output fmt_result_t result
);

    logic      conv_busy;
    logic      emit_busy;
    logic      accept;
    conv_res_t conv_res;

    assign accept = start && !busy;
    assign busy   = conv_busy || emit_busy;

    ittf_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .item  (item),
        .busy  (conv_busy),
        .res   (conv_res)
    );

    ittf_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .conv   (conv_res),
        .busy   (emit_busy),
        .strobe (strobe),
        .result (result)
    );

endmodule

[tb/integer_to_text_formatter_tb.sv]
// integer_to_text_formatter_tb: self-checking testbench for the integer-to-text formatter
// holds a scoreboard class that predicts the characters of each accepted value
// depends on ittf_pkg and the integer_to_text_formatter rtl
module integer_to_text_formatter_tb;
    import ittf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS   = 85;
    localparam int SETTLE_CYC   = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PERCENT = 17;

    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    class text_scoreboard;
        fmt_result_t expected_chars[$];
        int          errors;
        int          values_seen;
        int          chars_seen;

        function new();
            errors      = 0;
            values_seen = 0;
            chars_seen  = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_value(input fmt_item_t it);
            bit [VALUE_W-1:0]  mag;
            bit                neg;
            bit                hex;
            bit [DIGIT_W-1:0]  digit_q[$];
            int                len;
            int                zeros;
            bit [DIGIT_W-1:0]  d;
            fmt_result_t       r;
            mag = it.value;
            neg = 1'b0;
            hex = 1'b0;
            case (it.format_kind)
                KIND_S32:
                begin
                    mag = {32'd0, it.value[31:0]};
                    if (mag[31])
                    begin
                        neg = 1'b1;
                        mag = 64'h1_0000_0000 - mag;
                    end
                end
                KIND_U32: mag = {32'd0, it.value[31:0]};
                KIND_H32:
                begin
                    mag = {32'd0, it.value[31:0]};
                    hex = 1'b1;
                end
                KIND_S64:
                begin
                    if (mag[63])
                    begin
                        neg = 1'b1;
                        mag = -mag;
                    end
                end
                KIND_U64: ;
                KIND_H64: hex = 1'b1;
                default: return;
            endcase
            values_seen++;
            do
            begin
                if (hex)
                begin
                    d   = mag[3:0];
                    mag = mag >> 4;
                end
                else
                begin
                    d   = DIGIT_W'(mag % 10);
                    mag = mag / 10;
                end
                digit_q.push_front(d);
            end
            while (mag != 0 && digit_q.size() < NUM_DIGITS);
            len   = digit_q.size() + (neg ? 1 : 0);
            zeros = (it.pad_width > len) ? it.pad_width - len : 0;
            if (neg)
            begin
                r.char_code = CH_MINUS;
                r.last      = 1'b0;
                expected_chars.push_back(r);
            end
            repeat (zeros)
            begin
                r.char_code = CH_ZERO;
                r.last      = 1'b0;
                expected_chars.push_back(r);
            end
            foreach (digit_q[i])
            begin
                d           = digit_q[i];
                r.char_code = (d < 10) ? CH_ZERO + CHAR_W'(d) : CH_HEX_BASE + CHAR_W'(d);
                r.last      = (i == digit_q.size() - 1);
                expected_chars.push_back(r);
            end
        endfunction

        task check_char(input fmt_result_t got);
            fmt_result_t want;
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("character 0x%02h with no transaction pending", got.char_code));
                return;
            end
            want = expected_chars.pop_front();
            if (got.char_code !== want.char_code)
                report($sformatf("char_code got 0x%02h want 0x%02h",
                                 got.char_code, want.char_code));
            if (got.last !== want.last)
                report($sformatf("last got %b want %b (char 0x%02h)",
                                 got.last, want.last, want.char_code));
        endtask

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    fmt_item_t   item;
    logic        busy;
    logic        strobe;
    fmt_result_t result;

    text_scoreboard sb;
    int             cycles;
    bit             idle_enable;

    integer_to_text_formatter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_value(item);
        if (rst_n && strobe)
            sb.check_char(result);
    end

    function automatic fmt_item_t make_item(input logic [VALUE_W-1:0] v,
                                            input logic [KIND_W-1:0] k,
                                            input logic [PAD_W-1:0] p);
        fmt_item_t it;
        it.value       = v;
        it.format_kind = k;
        it.pad_width   = p;
        return it;
    endfunction

    task automatic send_item(input fmt_item_t it);
        if (idle_enable && $urandom_range(99) < IDLE_PERCENT)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off the sender until every pending character has come out
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = {$urandom, $urandom};
            1: v = {$urandom, 32'(int'($urandom_range(0, 999)))};
            2: v = 64'($urandom_range(0, 99));
            3: v = {$urandom, 1'b1, 31'($urandom_range(0, 9))};
            4: v = {1'b1, 63'($urandom_range(0, 9))};
            5: v = -64'($urandom_range(1, 1000));
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    function automatic logic [KIND_W-1:0] rand_kind();
        if ($urandom_range(99) < 6)
            return $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
        return KIND_W'($urandom_range(KIND_S32, KIND_H64));
    endfunction

    function automatic logic [PAD_W-1:0] rand_pad();
        if ($urandom_range(99) < 15)
            return PAD_W'($urandom_range(0, 63));
        return PAD_W'($urandom_range(0, 24));
    endfunction

    initial
    begin
        int        n;
        fmt_item_t it;
        sb          = new();
        idle_enable = 1'b1;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(64'd0, KIND_S32, 6'd0));
        send_item(make_item(64'hFFFF_FFFF_8000_0000, KIND_S32, 6'd0));
        send_item(make_item(64'h0000_0000_7FFF_FFFF, KIND_S32, 6'd12));
        send_item(make_item(64'h1234_5678_FFFF_FFFB, KIND_S32, 6'd2));
        send_item(make_item(64'h0000_0000_FFFF_FFFB, KIND_S32, 6'd1));
        send_item(make_item(64'h0000_0000_FFFF_FFFB, KIND_S32, 6'd9));
        send_item(make_item(64'hFFFF_FFFF_FFFF_FFFF, KIND_U32, 6'd0));
        send_item(make_item(64'hAAAA_AAAA_0000_007B, KIND_U32, 6'd3));
        send_item(make_item(64'h0000_0000_0000_0000, KIND_U32, 6'd63));
        send_item(make_item(64'h5555_5555_DEAD_BEEF, KIND_H32, 6'd12));
        send_item(make_item(64'hFFFF_FFFF_0000_0000, KIND_H32, 6'd0));
        send_item(make_item(64'h8000_0000_0000_0000, KIND_S64, 6'd63));
        send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, KIND_S64, 6'd0));
        send_item(make_item(64'hFFFF_FFFF_FFFF_FFFF, KIND_S64, 6'd5));
        send_item(make_item(64'hFFFF_FFFF_FFFF_FFFF, KIND_U64, 6'd0));
        send_item(make_item(64'd10_000_000_000_000_000_000, KIND_U64, 6'd20));
        send_item(make_item(64'd0, KIND_U64, 6'd1));
        send_item(make_item(64'hFFFF_FFFF_FFFF_FFFF, KIND_H64, 6'd0));
        send_item(make_item(64'd0, KIND_H64, 6'd63));
        send_item(make_item(64'h0000_0000_00AB_CDEF, KIND_H64, 6'd63));
        send_item(make_item(64'h1234_5678_9ABC_DEF0, KIND_SPARE_A, 6'd63));
        send_item(make_item(64'hFFFF_FFFF_FFFF_FFFF, KIND_SPARE_B, 6'd0));
        drain();
        send_item(make_item(64'd9, KIND_U32, 6'd63));

        n = 0;
        while (n < RAND_ITEMS)
        begin
            it.value       = rand_value();
            it.format_kind = rand_kind();
            it.pad_width   = rand_pad();
            idle_enable    = !(n >= 40 && n < 75);
            send_item(it);
            if (it.format_kind != KIND_SPARE_A && it.format_kind != KIND_SPARE_B)
                n++;
            if (n == 20 || n == 60)
                drain();
        end
        drain();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d characters never came out", sb.pending()));
        $display("covered %0d values over all six kinds, pads 0 to 63, spare kinds included",
                 sb.values_seen);
        $display("checked %0d characters in %0d cycles", sb.chars_seen, cycles);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
